[src/keyframe_sampler_with_easing_defines.svh]
// Assertion macros for the keyframe sampler with easing.
`ifndef KEYFRAME_SAMPLER_WITH_EASING_DEFINES_SVH
`define KEYFRAME_SAMPLER_WITH_EASING_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define KFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe sampler check failed");
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define KFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe sampler check failed");
`else
`define KFS_ASSERT_IMP(lbl, ante, cons)
`define KFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/kfs_pkg.sv]
// Shared types and constants of the keyframe sampler with easing.
package kfs_pkg;

    // Operation codes.
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_NEAREST = 2'd1;
    localparam logic [1:0] OP_INTERP  = 2'd2;

    // Easing curve codes.
    localparam logic [1:0] CURVE_LINEAR   = 2'd0;
    localparam logic [1:0] CURVE_EASE_IN  = 2'd1;
    localparam logic [1:0] CURVE_EASE_OUT = 2'd2;
    localparam logic [1:0] CURVE_IN_OUT   = 2'd3;

    // Result status codes.
    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_EMPTY   = 3'd1;
    localparam logic [2:0] STATUS_BAD_DUR = 3'd2;
    localparam logic [2:0] STATUS_FULL    = 3'd3;
    localparam logic [2:0] STATUS_ADDED   = 3'd4;

    // Divider step counts and fixed-point one.
    localparam logic [5:0]  MOD_STEPS  = 6'd32;
    localparam logic [5:0]  FRAC_STEPS = 6'd16;
    localparam logic [16:0] Q_ONE      = 17'h10000;

    // Multiplier sequence steps.
    localparam logic [2:0] STEP_EASE = 3'd0;
    localparam logic [2:0] STEP_SX   = 3'd1;
    localparam logic [2:0] STEP_SY   = 3'd2;
    localparam logic [2:0] STEP_ROT  = 3'd3;
    localparam logic [2:0] STEP_COL3 = 3'd7;

    typedef struct packed {
        logic [31:0] duration;
        logic [63:0] rect;
        logic [31:0] scale;
        logic [31:0] rotation;
        logic [31:0] color;
        logic [1:0]  curve;
        logic [31:0] offset;
    } frame_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] index;
        frame_t     frame;
    } result_t;

    typedef struct packed {
        logic       start;
        logic [5:0] steps;
    } div_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FRAC,
        ST_MUL,
        ST_ACC,
        ST_LAST,
        ST_EMIT
    } state_t;

endpackage

[src/kfs_div.sv]
// Shift-subtract divider shared for the time wrap and the frame fraction.
module kfs_div #(
    parameter int REM_W = 39
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kfs_pkg::div_ctrl_t ctrl,
    input  logic [REM_W-1:0]   init_rem,
    input  logic [31:0]        dividend,
    input  logic [REM_W-1:0]   divisor,
    output logic               done,
    output logic [REM_W-1:0]   remainder,
    output logic [31:0]        quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsr_reg;
    logic [31:0]      dvd_reg;
    logic [31:0]      quo_reg;
    logic [REM_W:0]   rem_sh;
    logic [REM_W:0]   rem_sub;
    logic             fits;

    // One quotient bit per cycle.
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctrl.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder, dividend and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= init_rem;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign quotient  = quo_reg;

endmodule

[src/keyframe_sampler_with_easing.sv]
// Top level of the keyframe sampler with easing: frame table, sequencer and blend unit.
//
//   Channel   Handshake              Direction  Contents
//   cfg       cfg_we                 in         loop enable bit (cfg_wdata)
//   in        in_valid / in_ready    in         operation and frame fields
//   out       out_valid / out_ready  out        status and selected frame
//
// A sample wraps its time when looping, then walks the frame table, or reads the last
// frame when past the total; an interpolated sample then adds the fraction divide and
// the blend multiplies. The frame walk over the one read port of the frame memory and
// the shared bit-serial divider dominate the sample time.
// Reset clears the frame count, total time and loop enable; the frame memory is not cleared.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register while the next transaction is taken and worked on.
`include "keyframe_sampler_with_easing_defines.svh"

module keyframe_sampler_with_easing #(
    parameter int MAX_FRAMES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [31:0]        duration,
    input  logic [31:0]        sample_time,
    input  logic [63:0]        rect_packed,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [31:0] rotation,
    input  logic [31:0]        color_rgba,
    input  logic [1:0]         curve,
    input  logic [31:0]        offset_packed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [5:0]         frame_index,
    output logic [31:0]        out_duration,
    output logic [63:0]        out_rect,
    output logic signed [15:0] out_scale_x,
    output logic signed [15:0] out_scale_y,
    output logic signed [31:0] out_rotation,
    output logic [31:0]        out_color,
    output logic [1:0]         out_curve,
    output logic [31:0]        out_offset
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int TOT_W = 32 + CNT_W;

    kfs_pkg::state_t    state_reg;
    kfs_pkg::state_t    state_next;
    logic               loop_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [1:0]         op_reg;
    logic [31:0]        ct_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [TOT_W-1:0]   acc_reg;
    kfs_pkg::frame_t    cur_reg;
    logic [15:0]        t_reg;
    logic [16:0]        e_reg;
    logic [2:0]         step_reg;
    logic signed [51:0] prod_reg;
    kfs_pkg::result_t   res_reg;
    kfs_pkg::result_t   out_reg;
    logic               out_valid_reg;

    kfs_pkg::frame_t    mem [MAX_FRAMES];
    kfs_pkg::frame_t    rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    kfs_pkg::frame_t    wr_data;

    kfs_pkg::div_ctrl_t div_ctrl;
    logic [TOT_W-1:0]   div_init;
    logic [31:0]        div_dvd;
    logic [TOT_W-1:0]   div_dsr;
    logic               div_done;
    logic [TOT_W-1:0]   div_rem;
    logic [31:0]        div_quo;

    logic               accept;
    logic               full;
    logic               out_free;
    logic [TOT_W-1:0]   st_ext;
    logic [TOT_W-1:0]   ct_ext;
    logic [TOT_W-1:0]   dur_ext;
    logic [TOT_W-1:0]   acc_new;
    logic               hit;
    logic               last_idx;
    logic [17:0]        ease_m;
    logic [16:0]        ease_e;
    logic [1:0]         col_j;
    logic signed [33:0] mul_x;
    logic signed [17:0] mul_y;
    logic signed [51:0] blend_q;
    logic [2:0]         new_status;
    logic [5:0]         new_index;

    // Shared divider for the time wrap and the frame fraction.
    kfs_div #(
        .REM_W(TOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .init_rem (div_init),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .remainder(div_rem),
        .quotient (div_quo)
    );

    // Common compares and sums.
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == kfs_pkg::ST_IDLE);
    assign full     = (count_reg >= CNT_W'(MAX_FRAMES));
    assign out_free = !out_valid_reg || out_ready;
    assign st_ext   = {{CNT_W{1'b0}}, sample_time};
    assign ct_ext   = {{CNT_W{1'b0}}, ct_reg};
    assign dur_ext  = {{CNT_W{1'b0}}, rd_data_reg.duration};
    assign acc_new  = acc_reg + dur_ext;
    assign hit      = (ct_ext < acc_new);
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg);

    // Frame write on an accepted add with a nonzero duration while the table is not full.
    assign wr_en = accept && (operation == kfs_pkg::OP_ADD) && (duration != 32'd0) && !full;
    always_comb
    begin
        wr_data.duration = duration;
        wr_data.rect     = rect_packed;
        wr_data.scale    = {scale_y, scale_x};
        wr_data.rotation = rotation;
        wr_data.color    = color_rgba;
        wr_data.curve    = curve;
        wr_data.offset   = offset_packed;
    end

    // Status and index of a newly accepted transaction.
    always_comb
    begin
        new_status = kfs_pkg::STATUS_OK;
        new_index  = '0;
        if (operation == kfs_pkg::OP_ADD)
        begin
            if (duration == 32'd0)
            begin
                new_status = kfs_pkg::STATUS_BAD_DUR;
            end
            else if (full)
            begin
                new_status = kfs_pkg::STATUS_FULL;
            end
            else
            begin
                new_status = kfs_pkg::STATUS_ADDED;
                new_index  = 6'(count_reg);
            end
        end
        else if (count_reg == '0)
        begin
            new_status = kfs_pkg::STATUS_EMPTY;
        end
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[IDX_W'(count_reg)] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, memory reads and divider starts.
    always_comb
    begin
        state_next     = state_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.steps = kfs_pkg::MOD_STEPS;
        div_init       = '0;
        div_dvd        = sample_time;
        div_dsr        = total_reg;
        unique case (state_reg)
            kfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        kfs_pkg::OP_ADD:
                        begin
                            state_next = kfs_pkg::ST_EMIT;
                        end
                        kfs_pkg::OP_NEAREST, kfs_pkg::OP_INTERP:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = kfs_pkg::ST_EMIT;
                            end
                            else if (loop_reg)
                            begin
                                div_ctrl.start = 1'b1;
                                state_next     = kfs_pkg::ST_MOD;
                            end
                            else if (st_ext >= total_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(count_reg - CNT_W'(1));
                                state_next = kfs_pkg::ST_LAST;
                            end
                            else
                            begin
                                state_next = kfs_pkg::ST_WALK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = kfs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            kfs_pkg::ST_MOD:
            begin
                if (div_done)
                begin
                    state_next = kfs_pkg::ST_WALK_RD;
                end
            end
            kfs_pkg::ST_WALK_RD:
            begin
                rd_en      = 1'b1;
                state_next = kfs_pkg::ST_WALK_CHK;
            end
            kfs_pkg::ST_WALK_CHK:
            begin
                if (hit)
                begin
                    if ((op_reg == kfs_pkg::OP_NEAREST) || last_idx)
                    begin
                        state_next = kfs_pkg::ST_EMIT;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                        div_ctrl.steps = kfs_pkg::FRAC_STEPS;
                        div_init       = ct_ext - acc_reg;
                        div_dvd        = '0;
                        div_dsr        = dur_ext;
                        state_next     = kfs_pkg::ST_FRAC;
                    end
                end
                else
                begin
                    state_next = kfs_pkg::ST_WALK_RD;
                end
            end
            kfs_pkg::ST_FRAC:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + IDX_W'(1);
                if (div_done)
                begin
                    state_next = kfs_pkg::ST_MUL;
                end
            end
            kfs_pkg::ST_MUL:
            begin
                state_next = kfs_pkg::ST_ACC;
            end
            kfs_pkg::ST_ACC:
            begin
                if (step_reg == kfs_pkg::STEP_COL3)
                begin
                    state_next = kfs_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = kfs_pkg::ST_MUL;
                end
            end
            kfs_pkg::ST_LAST:
            begin
                state_next = kfs_pkg::ST_EMIT;
            end
            kfs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = kfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Ease multiplier operand from the fraction and the current frame's curve.
    always_comb
    begin
        case (cur_reg.curve)
            kfs_pkg::CURVE_EASE_OUT:
                ease_m = 18'(kfs_pkg::Q_ONE) - {2'b00, t_reg};
            kfs_pkg::CURVE_IN_OUT:
                ease_m = t_reg[15] ? (18'(2 * 65536) - {1'b0, t_reg, 1'b0}) : {2'b00, t_reg};
            default:
                ease_m = {2'b00, t_reg};
        endcase
    end

    // Eased fraction from the squared operand.
    always_comb
    begin
        case (cur_reg.curve)
            kfs_pkg::CURVE_EASE_IN:
                ease_e = 17'(prod_reg >>> 16);
            kfs_pkg::CURVE_EASE_OUT:
                ease_e = kfs_pkg::Q_ONE - 17'(prod_reg >>> 16);
            kfs_pkg::CURVE_IN_OUT:
                ease_e = t_reg[15] ? (kfs_pkg::Q_ONE - 17'(prod_reg >>> 17))
                                   : 17'(prod_reg >>> 15);
            default:
                ease_e = {1'b0, t_reg};
        endcase
    end

    // Shared multiplier operands: ease square, then each blend difference times ease.
    assign col_j = step_reg[1:0];
    always_comb
    begin
        mul_y = signed'({1'b0, e_reg});
        case (step_reg)
            kfs_pkg::STEP_EASE:
            begin
                mul_x = signed'({16'd0, ease_m});
                mul_y = signed'(ease_m);
            end
            kfs_pkg::STEP_SX:
                mul_x = 34'(signed'(rd_data_reg.scale[15:0]))
                      - 34'(signed'(cur_reg.scale[15:0]));
            kfs_pkg::STEP_SY:
                mul_x = 34'(signed'(rd_data_reg.scale[31:16]))
                      - 34'(signed'(cur_reg.scale[31:16]));
            kfs_pkg::STEP_ROT:
                mul_x = 34'(signed'(rd_data_reg.rotation)) - 34'(signed'(cur_reg.rotation));
            default:
                mul_x = signed'({26'd0, rd_data_reg.color[8*col_j +: 8]})
                      - signed'({26'd0, cur_reg.color[8*col_j +: 8]});
        endcase
    end

    // Floor of the product over one in Q0.16.
    assign blend_q = prod_reg >>> 16;

    // Sequencer datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            kfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_reg  <= operation;
                    ct_reg  <= sample_time;
                    idx_reg <= '0;
                    acc_reg <= '0;
                    res_reg <= '{status: new_status, index: new_index, frame: '0};
                end
            end
            kfs_pkg::ST_MOD:
            begin
                if (div_done)
                begin
                    ct_reg <= div_rem[31:0];
                end
            end
            kfs_pkg::ST_WALK_CHK:
            begin
                acc_reg       <= acc_new;
                cur_reg       <= rd_data_reg;
                res_reg.frame <= rd_data_reg;
                res_reg.index <= 6'(idx_reg);
                if (!hit)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            kfs_pkg::ST_FRAC:
            begin
                if (div_done)
                begin
                    t_reg    <= div_quo[15:0];
                    step_reg <= kfs_pkg::STEP_EASE;
                end
            end
            kfs_pkg::ST_MUL:
            begin
                prod_reg <= mul_x * mul_y;
            end
            kfs_pkg::ST_ACC:
            begin
                step_reg <= step_reg + 3'd1;
                case (step_reg)
                    kfs_pkg::STEP_EASE:
                        e_reg <= ease_e;
                    kfs_pkg::STEP_SX:
                        res_reg.frame.scale[15:0] <= cur_reg.scale[15:0] + blend_q[15:0];
                    kfs_pkg::STEP_SY:
                        res_reg.frame.scale[31:16] <= cur_reg.scale[31:16] + blend_q[15:0];
                    kfs_pkg::STEP_ROT:
                        res_reg.frame.rotation <= cur_reg.rotation + blend_q[31:0];
                    default:
                        res_reg.frame.color[8*col_j +: 8] <=
                            cur_reg.color[8*col_j +: 8] + blend_q[7:0];
                endcase
            end
            kfs_pkg::ST_LAST:
            begin
                res_reg.frame <= rd_data_reg;
                res_reg.index <= 6'(count_reg - CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    // Loop enable, frame count and total time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg  <= 1'b0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                loop_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
                total_reg <= total_reg + {{CNT_W{1'b0}}, duration};
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == kfs_pkg::ST_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == kfs_pkg::ST_EMIT) && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign frame_index  = out_reg.index;
    assign out_duration = out_reg.frame.duration;
    assign out_rect     = out_reg.frame.rect;
    assign out_scale_x  = out_reg.frame.scale[15:0];
    assign out_scale_y  = out_reg.frame.scale[31:16];
    assign out_rotation = out_reg.frame.rotation;
    assign out_color    = out_reg.frame.color;
    assign out_curve    = out_reg.frame.curve;
    assign out_offset   = out_reg.frame.offset;

    // Checks on the sequencer and the frame table.
    `KFS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_FRAMES))
    `KFS_ASSERT_IMP(a_div_owner, div_done, state_reg == kfs_pkg::ST_MOD || state_reg == kfs_pkg::ST_FRAC)
    `KFS_ASSERT_IMP(a_walk_in_table, state_reg == kfs_pkg::ST_WALK_CHK, CNT_W'(idx_reg) < count_reg)
    `KFS_ASSERT_NEXT(a_add_counts, wr_en, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

[tb/sv/keyframe_sampler_with_easing_tb.sv]
// Self-checking testbench for the keyframe sampler with easing.
module keyframe_sampler_with_easing_tb;

    localparam int NUM_FRAMES  = 64;
    localparam int RAND_ITEMS  = 1600;
    localparam int SETTLE      = 250;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] dur;
        logic [31:0] stime;
        logic [63:0] rect;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [31:0] rot;
        logic [31:0] col;
        logic [1:0]  crv;
        logic [31:0] off;
    } kf_item_t;

    typedef struct {
        logic [2:0]  st;
        logic [5:0]  idx;
        logic [31:0] dur;
        logic [63:0] rect;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [31:0] rot;
        logic [31:0] col;
        logic [1:0]  crv;
        logic [31:0] off;
    } kf_result_t;

    typedef struct {
        kf_item_t   it;
        bit         typed;
        logic [2:0] st;
        logic [5:0] idx;
    } kf_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic [31:0] duration = '0;
    logic [31:0] sample_time = '0;
    logic [63:0] rect_packed = '0;
    logic signed [15:0] scale_x = '0;
    logic signed [15:0] scale_y = '0;
    logic signed [31:0] rotation = '0;
    logic [31:0] color_rgba = '0;
    logic [1:0] curve = '0;
    logic [31:0] offset_packed = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [5:0] frame_index;
    logic [31:0] out_duration;
    logic [63:0] out_rect;
    logic signed [15:0] out_scale_x;
    logic signed [15:0] out_scale_y;
    logic signed [31:0] out_rotation;
    logic [31:0] out_color;
    logic [1:0] out_curve;
    logic [31:0] out_offset;

    keyframe_sampler_with_easing dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .duration(duration), .sample_time(sample_time), .rect_packed(rect_packed),
        .scale_x(scale_x), .scale_y(scale_y), .rotation(rotation),
        .color_rgba(color_rgba), .curve(curve), .offset_packed(offset_packed),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .frame_index(frame_index), .out_duration(out_duration), .out_rect(out_rect),
        .out_scale_x(out_scale_x), .out_scale_y(out_scale_y),
        .out_rotation(out_rotation), .out_color(out_color), .out_curve(out_curve),
        .out_offset(out_offset)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the frame table and the loop register.
    bit          shadow_loop;
    int          shadow_count;
    longint      shadow_total;
    logic [31:0] tbl_dur [NUM_FRAMES];
    logic [63:0] tbl_rect [NUM_FRAMES];
    logic [15:0] tbl_sx [NUM_FRAMES];
    logic [15:0] tbl_sy [NUM_FRAMES];
    logic [31:0] tbl_rot [NUM_FRAMES];
    logic [31:0] tbl_col [NUM_FRAMES];
    logic [1:0]  tbl_crv [NUM_FRAMES];
    logic [31:0] tbl_off [NUM_FRAMES];

    kf_result_t pending_q[$];
    int  errors = 0;
    int  results_seen = 0;
    int  samples_sent = 0;
    int  adds_sent = 0;
    int  accept_idle = 0;
    bit  quiet = 1'b0;
    int  hold_requests = 0;

    // Easing of a Q0.16 fraction, with 1.0 equal to 65536.
    function automatic longint eased(longint t, logic [1:0] c);
        longint u;
        case (c)
            kfs_pkg::CURVE_EASE_IN: eased = (t * t) >> 16;
            kfs_pkg::CURVE_EASE_OUT:
            begin
                u = 65536 - t;
                eased = 65536 - ((u * u) >> 16);
            end
            kfs_pkg::CURVE_IN_OUT:
            begin
                if (t < 32768)
                    eased = (2 * t * t) >> 16;
                else
                begin
                    u = 131072 - 2 * t;
                    eased = 65536 - ((u * u) >> 17);
                end
            end
            default: eased = t;
        endcase
    endfunction

    // Blend toward b by e, rounding toward minus infinity.
    function automatic longint mix(longint a, longint b, longint e);
        longint p;
        p = (b - a) * e;
        mix = a + (p >>> 16);
    endfunction

    function automatic kf_result_t frame_of(int i);
        kf_result_t r;
        r.st = kfs_pkg::STATUS_OK;
        r.idx = i[5:0];
        r.dur = tbl_dur[i];
        r.rect = tbl_rect[i];
        r.sx = tbl_sx[i];
        r.sy = tbl_sy[i];
        r.rot = tbl_rot[i];
        r.col = tbl_col[i];
        r.crv = tbl_crv[i];
        r.off = tbl_off[i];
        return r;
    endfunction

    // Applies one accepted transaction to the shadow table and returns its result.
    function automatic kf_result_t sampler_step(kf_item_t it);
        kf_result_t r;
        longint ct, acc, t, e, tmp;
        int i;
        r = '{default: '0};
        if (it.op == kfs_pkg::OP_ADD)
        begin
            if (it.dur == 0)
                r.st = kfs_pkg::STATUS_BAD_DUR;
            else if (shadow_count >= NUM_FRAMES)
                r.st = kfs_pkg::STATUS_FULL;
            else
            begin
                tbl_dur[shadow_count] = it.dur;
                tbl_rect[shadow_count] = it.rect;
                tbl_sx[shadow_count] = it.sx;
                tbl_sy[shadow_count] = it.sy;
                tbl_rot[shadow_count] = it.rot;
                tbl_col[shadow_count] = it.col;
                tbl_crv[shadow_count] = it.crv;
                tbl_off[shadow_count] = it.off;
                r.st = kfs_pkg::STATUS_ADDED;
                r.idx = shadow_count[5:0];
                shadow_count++;
                shadow_total += longint'(it.dur);
            end
            return r;
        end
        if (shadow_count == 0)
        begin
            r.st = kfs_pkg::STATUS_EMPTY;
            return r;
        end
        ct = longint'(it.stime);
        if (shadow_loop && shadow_total > 0)
            ct = ct % shadow_total;
        else if (ct >= shadow_total)
            return frame_of(shadow_count - 1);
        acc = 0;
        for (i = 0; i < shadow_count; i++)
        begin
            acc += longint'(tbl_dur[i]);
            if (ct < acc)
                break;
        end
        if (i >= shadow_count)
            i = shadow_count - 1;
        r = frame_of(i);
        if (it.op == kfs_pkg::OP_NEAREST || i + 1 >= shadow_count)
            return r;
        t = ((ct - (acc - longint'(tbl_dur[i]))) << 16) / longint'(tbl_dur[i]);
        if (t > 65535)
            t = 65535;
        e = eased(t, tbl_crv[i]);
        tmp = mix(longint'($signed(tbl_sx[i])), longint'($signed(tbl_sx[i+1])), e);
        r.sx = tmp[15:0];
        tmp = mix(longint'($signed(tbl_sy[i])), longint'($signed(tbl_sy[i+1])), e);
        r.sy = tmp[15:0];
        tmp = mix(longint'($signed(tbl_rot[i])), longint'($signed(tbl_rot[i+1])), e);
        r.rot = tmp[31:0];
        for (int j = 0; j < 4; j++)
        begin
            tmp = mix(longint'(tbl_col[i][8*j +: 8]), longint'(tbl_col[i+1][8*j +: 8]), e);
            r.col[8*j +: 8] = tmp[7:0];
        end
        return r;
    endfunction

    function automatic kf_item_t make_item(logic [1:0] op, logic [31:0] dur,
                                           logic [31:0] stime, logic [15:0] sx,
                                           logic [15:0] sy, logic [31:0] rot,
                                           logic [31:0] col, logic [1:0] crv);
        kf_item_t it;
        it.op = op;
        it.dur = dur;
        it.stime = stime;
        it.rect = {$urandom, $urandom};
        it.sx = sx;
        it.sy = sy;
        it.rot = rot;
        it.col = col;
        it.crv = crv;
        it.off = $urandom;
        return it;
    endfunction

    // Random transaction: mostly samples aimed at the stored timeline.
    function automatic kf_item_t random_item();
        kf_item_t it;
        int pick;
        longint span, tt;
        it = make_item(kfs_pkg::OP_INTERP, $urandom, $urandom, 16'($urandom),
                       16'($urandom), $urandom, $urandom, 2'($urandom_range(0, 3)));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            it.op = OP_IGNORED;
        else if (pick < ((shadow_count < NUM_FRAMES) ? 15 : 7))
        begin
            it.op = kfs_pkg::OP_ADD;
            pick = $urandom_range(0, 99);
            if (pick < 6)
                it.dur = 0;
            else if (shadow_count >= 60 && pick < 50)
                it.dur = 32'hFFFF_FFFF;
            else if (shadow_count < NUM_FRAMES)
                it.dur = $urandom_range(1, 32'h0003_0000);
        end
        else
        begin
            it.op = ($urandom_range(0, 2) == 0) ? kfs_pkg::OP_NEAREST : kfs_pkg::OP_INTERP;
            pick = $urandom_range(0, 99);
            span = shadow_total + shadow_total / 8 + 1;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            if (pick < 70)
                tt = longint'({$urandom, $urandom} % span);
            else if (pick < 90 && shadow_count > 0)
            begin
                tt = 0;
                for (int k = $urandom_range(0, shadow_count - 1); k >= 0; k--)
                    tt += longint'(tbl_dur[k]);
                tt = tt + $urandom_range(0, 2) - 1;
                if (tt < 0)
                    tt = 0;
                if (tt > 64'hFFFF_FFFF)
                    tt = 64'hFFFF_FFFF;
            end
            else
                tt = longint'($urandom);
            it.stime = tt[31:0];
        end
        return it;
    endfunction

    // Offers one transaction and waits for its acceptance.
    task automatic send_item(kf_item_t it, bit typed, logic [2:0] st, logic [5:0] idx);
        kf_result_t r;
        int gap;
        operation <= it.op;
        duration <= it.dur;
        sample_time <= it.stime;
        rect_packed <= it.rect;
        scale_x <= it.sx;
        scale_y <= it.sy;
        rotation <= it.rot;
        color_rgba <= it.col;
        curve <= it.crv;
        offset_packed <= it.off;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (it.op != OP_IGNORED)
        begin
            r = sampler_step(it);
            if (typed)
            begin
                r = '{default: '0};
                r.st = st;
                r.idx = idx;
            end
            pending_q.insert(pending_q.size(), r);
            if (it.op == kfs_pkg::OP_ADD)
                adds_sent++;
            else
                samples_sent++;
        end
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes the loop register once the block has gone idle.
    task automatic set_loop(bit v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_loop = v;
    endtask

    // Stimulus: directed rows, then four random phases over both loop settings.
    initial
    begin
        kf_row_t rows[$];
        kf_item_t it;
        longint tot;
        longint probe [10];
        shadow_loop = 1'b0;
        shadow_count = 0;
        shadow_total = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_loop(1'b0);

        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_NEAREST, 0, 0, 0, 0, 0, 0, 0),
                                   1, kfs_pkg::STATUS_EMPTY, 0});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_INTERP, 0, '1, 0, 0, 0, 0, 0),
                                   1, kfs_pkg::STATUS_EMPTY, 0});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0),
                                   1, kfs_pkg::STATUS_BAD_DUR, 0});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_ADD, 32'h1_0000, 0, 16'h8000,
                                   16'h8000, 32'h8000_0000, 32'h0, kfs_pkg::CURVE_LINEAR),
                                   1, kfs_pkg::STATUS_ADDED, 0});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_ADD, 32'h2_0000, 0, 16'h7FFF,
                                   16'h7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                   kfs_pkg::CURVE_EASE_IN), 1, kfs_pkg::STATUS_ADDED, 1});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_ADD, 32'h3_0000, 0, 16'h8000,
                                   16'h0100, 32'h8000_0000, 32'h0,
                                   kfs_pkg::CURVE_EASE_OUT), 1, kfs_pkg::STATUS_ADDED, 2});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_ADD, 32'h4_0000, 0, 16'h7FFF,
                                   16'hFF00, 32'h0001_0000, 32'h80FF_0180,
                                   kfs_pkg::CURVE_IN_OUT), 1, kfs_pkg::STATUS_ADDED, 3});
        rows.insert(rows.size(), '{make_item(kfs_pkg::OP_ADD, 32'h8000, 0, 16'h0000,
                                   16'h8000, 32'hFFFF_0000, 32'h7F00_FF01,
                                   kfs_pkg::CURVE_LINEAR), 1, kfs_pkg::STATUS_ADDED, 4});
        rows.insert(rows.size(), '{make_item(OP_IGNORED, '1, '1, '1, '1, '1, '1, '1),
                                   0, 0, 0});
        foreach (rows[k])
            rows[k].it.rect = (k == 3) ? 64'h0 : (k == 4) ? '1 : rows[k].it.rect;
        tot = 64'h0A_8000;
        probe = '{64'h0, 64'h8000, 64'h1_8000, 64'h3_0000, 64'h7_0000, 64'h7_C000,
                  64'h9_0000, tot - 1, tot, 64'hFFFF_FFFF};
        foreach (probe[k])
        begin
            rows.insert(rows.size(), '{make_item(kfs_pkg::OP_INTERP, 0, 32'(probe[k]),
                                       0, 0, 0, 0, 0), 0, 0, 0});
            rows.insert(rows.size(), rows[$]);
            rows[$].it.op = kfs_pkg::OP_NEAREST;
        end
        foreach (rows[k])
            send_item(rows[k].it, rows[k].typed, rows[k].st, rows[k].idx);

        // Wrapped samples past the total, including the largest time.
        set_loop(1'b1);
        send_item(make_item(kfs_pkg::OP_INTERP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, 0, 0);
        send_item(make_item(kfs_pkg::OP_INTERP, 0, 32'(tot + 64'h2_4000), 0, 0, 0, 0, 0),
                  0, 0, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_loop(ph[0]);
            for (int n = 0; n < RAND_ITEMS / 4; n++)
            begin
                if (ph == 3 && n >= RAND_ITEMS / 8)
                    quiet = 1'b1;
                if (ph == 1 && n == 100)
                    wait_drained();
                if (ph == 2 && n == 50)
                    hold_requests++;
                it = random_item();
                send_item(it, 0, 0, 0);
            end
        end
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d adds and %0d samples, table filled to %0d frames,",
                 adds_sent, samples_sent, shadow_count);
        $display("with both loop settings and random stalls on both channels.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result receiver: short random stalls and one long hold-off on request.
    always @(posedge clk)
    begin : receiver
        static int stall_left = 0;
        static int holds_done = 0;
        if (holds_done != hold_requests)
        begin
            holds_done = hold_requests;
            stall_left = 400;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic cmp_field(string name, logic [63:0] expv, logic [63:0] actv);
        if (expv !== actv)
        begin
            errors++;
            $display("%0t: mismatch on %s in result %0d: expected %h, actual %h",
                     $time, name, results_seen, expv, actv);
        end
    endtask

    // Result checker against the oldest pending prediction.
    always @(posedge clk)
    begin
        kf_result_t x;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                x = pending_q.pop_front();
                cmp_field("status", 64'(x.st), 64'(status));
                cmp_field("frame_index", 64'(x.idx), 64'(frame_index));
                cmp_field("out_duration", 64'(x.dur), 64'(out_duration));
                cmp_field("out_rect", x.rect, out_rect);
                cmp_field("out_scale_x", 64'(x.sx), 64'($unsigned(out_scale_x)));
                cmp_field("out_scale_y", 64'(x.sy), 64'($unsigned(out_scale_y)));
                cmp_field("out_rotation", 64'(x.rot), 64'($unsigned(out_rotation)));
                cmp_field("out_color", 64'(x.col), 64'(out_color));
                cmp_field("out_curve", 64'(x.crv), 64'(out_curve));
                cmp_field("out_offset", 64'(x.off), 64'(out_offset));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            accept_idle <= 0;
        else
            accept_idle <= accept_idle + 1;
        if (accept_idle >= STALL_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", accept_idle);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

[keyframe_sampler_with_easing.f]
+incdir+src
src/kfs_pkg.sv
src/kfs_div.sv
src/keyframe_sampler_with_easing.sv
tb/sv/keyframe_sampler_with_easing_tb.sv
